>>> rtl/fpp_pkg.sv
`timescale 1ns / 1ps
// fpp_pkg: shared constants, codes and types of the frame playback pacer.
// Used by fpp_ctrl, fpp_datapath and frame_playback_pacer; no dependencies.

package fpp_pkg;

    // Frame store depth and field widths
    localparam int FRAMES     = 256;
    localparam int FRAME_W    = 8;
    localparam int NOW_W      = 48;
    localparam int IVL_W      = 16;
    localparam int CNT_W      = 16;
    localparam int ACT_W      = 3;
    localparam int RUN_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 40;
    localparam int M_USER_W   = 2;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PLAY  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PAUSE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd4;

    // Run states
    localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
    localparam logic [RUN_W-1:0] RUN_PLAYING = 2'd1;
    localparam logic [RUN_W-1:0] RUN_PAUSED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EVERY      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_LO   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_HI   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_READY_CHK  = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture input item, clear result
        logic play;        // start playing from clamped frame
        logic pause;       // playing -> paused
        logic stop_item;   // stop item, report origin
        logic set_ready;   // write ready bit
        logic set_last;    // last frame time takes now
        logic halt;        // run state -> stopped (end of range)
        logic start_scan;  // probe = following frame of current
        logic show;        // probe frame is shown
        logic skip;        // count a skipped frame
        logic advance;     // probe = following frame of probe
        logic emit;        // load result into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic playing;
        logic time_back;
        logic due;
        logic next_ok_cur;
        logic next_ok_probe;
        logic ready;
        logic last_probe;
        logic every_frame;
        logic out_free;
    } sts_t;

    // A following frame exists for f within [lo, hi]
    function automatic logic has_next(input logic [FRAME_W-1:0] f,
                                      input logic [FRAME_W-1:0] lo,
                                      input logic [FRAME_W-1:0] hi,
                                      input logic loop_en);
        has_next = (lo != hi) && ((f < hi) || loop_en);
    endfunction

    // Following frame, wrapping to lo at or beyond hi
    function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] f,
                                                      input logic [FRAME_W-1:0] lo,
                                                      input logic [FRAME_W-1:0] hi);
        next_frame = (f >= hi) ? lo : f + FRAME_W'(1);
    endfunction

endpackage

>>> rtl/fpp_ctrl.sv
`timescale 1ns / 1ps
// fpp_ctrl: sequencing state machine of the frame playback pacer.
// Depends on fpp_pkg for command and status types and action codes.

module fpp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fpp_pkg::sts_t  sts,
    output fpp_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_CHK    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_FINISH;
                case (sts.action)
                    fpp_pkg::ACT_TICK: begin
                        if (!sts.playing) begin
                            // no frame
                        end else if (sts.time_back) begin
                            cmd.set_last = 1'b1;
                        end else if (!sts.due) begin
                            // not yet due
                        end else if (!sts.next_ok_cur) begin
                            cmd.halt = 1'b1;
                        end else begin
                            cmd.start_scan = 1'b1;
                            state_next     = ST_RD;
                        end
                    end
                    fpp_pkg::ACT_PLAY:  cmd.play      = 1'b1;
                    fpp_pkg::ACT_PAUSE: cmd.pause     = 1'b1;
                    fpp_pkg::ACT_STOP:  cmd.stop_item = 1'b1;
                    fpp_pkg::ACT_SET:   cmd.set_ready = 1'b1;
                    default: ;
                endcase
            end
            ST_RD: begin
                // ready bit of the probe frame is being read
                state_next = ST_CHK;
            end
            ST_CHK: begin
                state_next = ST_FINISH;
                if (sts.ready) begin
                    cmd.show     = 1'b1;
                    cmd.set_last = 1'b1;
                end else if (!sts.every_frame) begin
                    cmd.skip = 1'b1;
                    if (!sts.next_ok_probe) begin
                        cmd.halt = 1'b1;
                    end else if (sts.last_probe) begin
                        cmd.set_last = 1'b1;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/fpp_datapath.sv
`timescale 1ns / 1ps
// fpp_datapath: configuration, playback state, ready bit store, probe
// scan registers and output register. Depends on fpp_pkg.

module fpp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [fpp_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic [fpp_pkg::ACT_W-1:0]           s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [fpp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fpp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fpp_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [fpp_pkg::M_USER_W-1:0]        m_tuser,
    input  fpp_pkg::cmd_t                       cmd,
    output fpp_pkg::sts_t                       sts
);

    localparam int FW = fpp_pkg::FRAME_W;
    localparam int NW = fpp_pkg::NOW_W;
    localparam int CW = fpp_pkg::CNT_W;

    // Configuration registers
    logic [fpp_pkg::IVL_W-1:0] ivl_reg;
    logic                      loop_reg;
    logic                      every_reg;
    logic [FW-1:0]             first_reg;
    logic [FW-1:0]             last_cfg_reg;
    logic                      chk_reg;

    // Playback state
    logic [fpp_pkg::RUN_W-1:0] run_reg;
    logic [FW-1:0]             origin_reg;
    logic [NW-1:0]             last_ms_reg;
    logic [CW-1:0]             skip_reg;

    // Captured item
    logic [fpp_pkg::ACT_W-1:0] act_reg;
    logic [NW-1:0]             now_reg;
    logic [FW-1:0]             ft_reg;
    logic                      flag_reg;

    // Scan
    logic [FW-1:0]             probe_reg;
    logic [FW-1:0]             k_reg;

    // Ready bit store with per-entry written marks
    logic                      ready_mem [fpp_pkg::FRAMES];
    logic [fpp_pkg::FRAMES-1:0] ready_vld_reg;
    logic                      mem_rd_reg;
    logic                      vld_rd_reg;

    // Result being built
    logic                      res_fvalid_reg;
    logic [FW-1:0]             res_frame_reg;
    logic                      res_svalid_reg;
    logic [FW-1:0]             res_stime_reg;

    // Output register
    logic                      m_tvalid_reg;
    logic [fpp_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [fpp_pkg::M_USER_W-1:0] m_tuser_reg;

    logic [FW-1:0]             range_hi;
    logic [NW-1:0]             elapsed;
    logic [fpp_pkg::IVL_W-1:0] ivl_eff;
    logic [FW-1:0]             origin_clamp;

    assign range_hi = (last_cfg_reg > first_reg) ? last_cfg_reg : first_reg;
    assign elapsed  = now_reg - last_ms_reg;
    assign ivl_eff  = (ivl_reg == '0) ? fpp_pkg::IVL_W'(1) : ivl_reg;
    assign origin_clamp = (ft_reg < first_reg) ? first_reg :
                          ((ft_reg > range_hi) ? range_hi : ft_reg);

    // Status toward the controller
    always_comb begin
        sts.action        = act_reg;
        sts.playing       = (run_reg == fpp_pkg::RUN_PLAYING);
        sts.time_back     = (now_reg < last_ms_reg);
        sts.due           = (elapsed >= NW'(ivl_eff));
        sts.next_ok_cur   = fpp_pkg::has_next(ft_reg, first_reg, range_hi, loop_reg);
        sts.next_ok_probe = fpp_pkg::has_next(probe_reg, first_reg, range_hi, loop_reg);
        sts.ready         = !chk_reg || (vld_rd_reg && mem_rd_reg);
        sts.last_probe    = (k_reg == (range_hi - first_reg));
        sts.every_frame   = every_reg;
        sts.out_free      = !m_tvalid_reg || m_tready;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ivl_reg      <= fpp_pkg::IVL_W'(100);
            loop_reg     <= 1'b0;
            every_reg    <= 1'b0;
            first_reg    <= '0;
            last_cfg_reg <= '1;
            chk_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fpp_pkg::CFG_INTERVAL:  ivl_reg      <= cfg_wdata;
                fpp_pkg::CFG_LOOP:      loop_reg     <= cfg_wdata[0];
                fpp_pkg::CFG_EVERY:     every_reg    <= cfg_wdata[0];
                fpp_pkg::CFG_RANGE_LO:  first_reg    <= cfg_wdata[FW-1:0];
                fpp_pkg::CFG_RANGE_HI:  last_cfg_reg <= cfg_wdata[FW-1:0];
                fpp_pkg::CFG_READY_CHK: chk_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg  <= s_tuser;
            now_reg  <= s_tdata[NW-1:0];
            ft_reg   <= s_tdata[NW+FW-1:NW];
            flag_reg <= s_tdata[NW+FW];
        end
    end

    // Run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= fpp_pkg::RUN_STOPPED;
        end else if (cmd.play) begin
            run_reg <= fpp_pkg::RUN_PLAYING;
        end else if (cmd.pause && run_reg == fpp_pkg::RUN_PLAYING) begin
            run_reg <= fpp_pkg::RUN_PAUSED;
        end else if (cmd.stop_item || cmd.halt) begin
            run_reg <= fpp_pkg::RUN_STOPPED;
        end
    end

    // Origin, last frame time, skipped count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg  <= '0;
            last_ms_reg <= '0;
            skip_reg    <= '0;
        end else begin
            if (cmd.play) begin
                origin_reg <= origin_clamp;
            end
            if (cmd.play || cmd.set_last) begin
                last_ms_reg <= now_reg;
            end
            if (cmd.play) begin
                skip_reg <= '0;
            end else if (cmd.skip && skip_reg != '1) begin
                skip_reg <= skip_reg + CW'(1);
            end
        end
    end

    // Probe frame and probe count
    always_ff @(posedge aclk) begin
        if (cmd.start_scan) begin
            probe_reg <= fpp_pkg::next_frame(ft_reg, first_reg, range_hi);
            k_reg     <= '0;
        end else if (cmd.advance) begin
            probe_reg <= fpp_pkg::next_frame(probe_reg, first_reg, range_hi);
            k_reg     <= k_reg + FW'(1);
        end
    end

    // Ready bit store: write on set item, registered read at probe
    always_ff @(posedge aclk) begin
        if (cmd.set_ready) begin
            ready_mem[ft_reg] <= flag_reg;
        end
        mem_rd_reg <= ready_mem[probe_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_vld_reg <= '0;
            vld_rd_reg    <= 1'b0;
        end else begin
            if (cmd.set_ready) begin
                ready_vld_reg[ft_reg] <= 1'b1;
            end
            vld_rd_reg <= ready_vld_reg[probe_reg];
        end
    end

    // Result fields of the current item
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            res_fvalid_reg <= 1'b0;
            res_frame_reg  <= '0;
            res_svalid_reg <= 1'b0;
            res_stime_reg  <= '0;
        end else begin
            if (cmd.show) begin
                res_fvalid_reg <= 1'b1;
                res_frame_reg  <= probe_reg;
            end
            if (cmd.stop_item && run_reg != fpp_pkg::RUN_STOPPED) begin
                res_svalid_reg <= 1'b1;
                res_stime_reg  <= origin_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {6'b0, skip_reg, run_reg, res_stime_reg, res_frame_reg};
            m_tuser_reg <= {res_svalid_reg, res_fvalid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/frame_playback_pacer.sv
`timescale 1ns / 1ps
// frame_playback_pacer: top level joining controller and datapath.
// Depends on fpp_pkg, fpp_ctrl and fpp_datapath.
//
// Usage:
//   Input items arrive on the s_ stream: s_tuser carries the action (tick,
//   play, pause, stop, set ready bit), s_tdata the time, frame and flag.
//   Every item gives exactly one result on the m_ stream: the shown frame or
//   the stop origin with their flags in m_tuser, plus run state and the
//   dropped-frame count in m_tdata.
//   Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata
//   while no item is in flight.
//   Items are worked one at a time. A play, pause, stop, set-ready item or a
//   tick that probes no frame goes from acceptance through the evaluate and
//   finish states; a tick that scans adds a read and a check state for each
//   of P probed frames (P up to 256), since each probe waits on the registered
//   read of the ready bit store. s_tready returns as m_tvalid rises.
//   A result waits in the output register while m_tready is low; the next
//   item may be accepted and worked meanwhile, and its result is held back
//   until the register frees.
//   Reset stops playback, clears origin, time, count and all ready bits, and
//   loads the register defaults. No clearing pass is needed.

module frame_playback_pacer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpp_pkg::S_DATA_W-1:0]   s_tdata,   // now_ms[47:0], frame_time[55:48],
                                                      // ready_flag[56], zero fill
    input  logic [fpp_pkg::ACT_W-1:0]      s_tuser,   // action[2:0]
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpp_pkg::M_DATA_W-1:0]   m_tdata,   // frame_out[7:0], stop_time[15:8],
                                                      // run_state[17:16],
                                                      // dropped_count[33:18], zero fill
    output logic [fpp_pkg::M_USER_W-1:0]   m_tuser,   // frame_valid[0], stop_valid[1]
    // Configuration writes
    input  logic                           cfg_wr_en,
    input  logic [fpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    fpp_pkg::cmd_t cmd;
    fpp_pkg::sts_t sts;

    fpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
